// ----- design/tccw_pkg.sv -----
// Shared types and constants for the text console character writer.
// No dependencies; every other design file except tccw_ram imports this package.
package tccw_pkg;

  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 6;
  localparam int OFS_W     = 13;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 3;
  localparam int TAB_STOP  = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR  = 2'd0,
    CFG_FG_BRIGHT = 2'd1,
    CFG_BG_COLOR  = 2'd2,
    CFG_BG_BRIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_SCROLL_BLANK,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;     // latch the accepted item
    logic put;         // apply a put-character command
    logic set_cur;     // apply a set-cursor command
    logic home;        // cursor to origin, sweep index to zero
    logic fill_init;   // write reset blank at sweep index, advance
    logic fill_blank;  // write current blank at sweep index, advance
    logic copy_rd;     // read the cell one row below the sweep index
    logic copy_wr;     // write read data at sweep index, advance
    logic cell_rd;     // read the addressed cell
    logic put_out;     // load the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scroll_need;
    logic  last_cell;
    logic  last_copy;
    logic  out_free;
  } ctl_status_t;

endpackage

// ----- design/text_console_char_writer.sv -----
// Text console character writer: a COLS x ROWS screen of 16-bit cells (character
// in bits 7..0, attribute in bits 15..8) and a cursor, one command per item:
// put character, set cursor, clear screen or read cell. Every item gives one
// result with the cursor after the command and, for a read, the cell word.
// Put, set and read go from acceptance through the decode and result states to
// the output register; clear first sweeps every cell. A put that moves the cursor
// below the last row scrolls the screen first: the single screen RAM moves one
// cell per read/write pair, then the last row is blanked. After reset a clearing
// pass fills the screen with blanks while in_ready stays low; configuration writes
// are taken at any time. A finished result waits in an output register while
// the next item is accepted. Depends on tccw_pkg, tccw_ctrl and tccw_datapath.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tccw_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tccw_pkg::KIND_W-1:0]     kind,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tccw_pkg::COL_W-1:0]      col,
  input  logic [tccw_pkg::ROW_W-1:0]      row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tccw_pkg::COL_W-1:0]      cursor_x,
  output logic [tccw_pkg::ROW_W-1:0]      cursor_y,
  output logic [tccw_pkg::OFS_W-1:0]      cursor_offset,
  output logic [tccw_pkg::CELL_W-1:0]     cell_data
);

  import tccw_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .kind          (kind),
    .char_code     (char_code),
    .col           (col),
    .row           (row),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .cursor_offset (cursor_offset),
    .cell_data     (cell_data)
  );

endmodule

// ----- design/tccw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tccw_ctrl.sv -----
// Controller state machine: sequences the reset fill, commands, clears, scrolls and result loads.
// Depends on tccw_pkg.
module tccw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tccw_pkg::ctl_status_t status,
  output tccw_pkg::ctl_cmd_t    cmd
);

  import tccw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.last_cell) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.kind)
          KIND_PUT:   state_next = status.scroll_need ? ST_SCROLL_RD : ST_RESULT;
          KIND_CLEAR: state_next = ST_CLEAR;
          default:    state_next = ST_RESULT;
        endcase
      end
      ST_CLEAR: begin
        if (status.last_cell) state_next = ST_RESULT;
      end
      ST_SCROLL_RD: state_next = ST_SCROLL_WR;
      ST_SCROLL_WR: begin
        state_next = status.last_copy ? ST_SCROLL_BLANK : ST_SCROLL_RD;
      end
      ST_SCROLL_BLANK: begin
        if (status.last_cell) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT: cmd.fill_init = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_DECODE: begin
        case (status.kind)
          KIND_PUT:   cmd.put     = 1'b1;
          KIND_SET:   cmd.set_cur = 1'b1;
          KIND_CLEAR: cmd.home    = 1'b1;
          default:    cmd.cell_rd = 1'b1;
        endcase
      end
      ST_CLEAR:        cmd.fill_blank = 1'b1;
      ST_SCROLL_RD:    cmd.copy_rd    = 1'b1;
      ST_SCROLL_WR:    cmd.copy_wr    = 1'b1;
      ST_SCROLL_BLANK: cmd.fill_blank = 1'b1;
      ST_RESULT:       cmd.put_out    = status.out_free;
      default: ;
    endcase
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put, cmd.fill_init, cmd.fill_blank, cmd.copy_wr}))
    else $error("more than one RAM write source");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_wr |-> $past(cmd.copy_rd))
    else $error("scroll write without preceding read");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.put_out |-> status.out_free)
    else $error("result loaded over a waiting item");

endmodule

// ----- design/tccw_datapath.sv -----
// Datapath: cursor, attribute registers, screen RAM, sweep index and output register.
// Depends on tccw_pkg and tccw_ram.
module tccw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tccw_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [tccw_pkg::KIND_W-1:0]     kind,
  input  logic [tccw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tccw_pkg::COL_W-1:0]      col,
  input  logic [tccw_pkg::ROW_W-1:0]      row,
  input  tccw_pkg::ctl_cmd_t              cmd,
  output tccw_pkg::ctl_status_t           status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tccw_pkg::COL_W-1:0]      cursor_x,
  output logic [tccw_pkg::ROW_W-1:0]      cursor_y,
  output logic [tccw_pkg::OFS_W-1:0]      cursor_offset,
  output logic [tccw_pkg::CELL_W-1:0]     cell_data
);

  import tccw_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam logic [COL_W:0] COLS_C = (COL_W+1)'(COLS);
  localparam logic [ROW_W:0] ROWS_C = (ROW_W+1)'(ROWS);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [OFS_W-1:0] a;
    a = OFS_W'(r) * OFS_W'(COLS) + OFS_W'(c);
    return a[ADDR_W-1:0];
  endfunction

  // attribute registers
  logic [2:0] fg_color;
  logic       fg_bright;
  logic [2:0] bg_color;
  logic       bg_bright;
  logic [ATTR_W-1:0] attr;
  logic [CELL_W-1:0] blank;

  // latched item
  kind_t             cmd_kind;
  logic [CHAR_W-1:0] cmd_char;
  logic [COL_W-1:0]  cmd_col;
  logic [ROW_W-1:0]  cmd_row;
  logic              in_range;

  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] idx;

  // put-character evaluation
  logic [COL_W:0]    pc;
  logic [ROW_W:0]    pr;
  logic              put_we;
  logic [ROW_W-1:0]  put_wr;
  logic [COL_W-1:0]  put_wc;
  logic [CELL_W-1:0] put_wdata;
  logic              scroll_need;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign attr  = {bg_bright, bg_color, fg_bright, fg_color};
  assign blank = {attr, CH_SPACE};

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color  <= 3'd7;
      fg_bright <= 1'b0;
      bg_color  <= 3'd0;
      bg_bright <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_FG_COLOR:  fg_color  <= cfg_wdata;
        CFG_FG_BRIGHT: fg_bright <= cfg_wdata[0];
        CFG_BG_COLOR:  bg_color  <= cfg_wdata;
        CFG_BG_BRIGHT: bg_bright <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_kind <= kind_t'(kind);
      cmd_char <= char_code;
      cmd_col  <= col;
      cmd_row  <= row;
    end
  end

  assign in_range = ({1'b0, cmd_row} < ROWS_C) && ({1'b0, cmd_col} < COLS_C);

  always_comb begin
    pc        = {1'b0, cur_col};
    pr        = {1'b0, cur_row};
    put_we    = 1'b0;
    put_wr    = cur_row;
    put_wc    = cur_col;
    put_wdata = {attr, cmd_char};
    case (cmd_char)
      CH_BS: begin
        // at the origin backspace does nothing
        if (cur_col != '0 || cur_row != '0) begin
          put_we    = 1'b1;
          put_wdata = blank;
          if (cur_col == '0) begin
            pr = pr - 1'b1;
            pc = COLS_C - 1'b1;
          end else begin
            pc = pc - 1'b1;
          end
        end
        put_wr = pr[ROW_W-1:0];
        put_wc = pc[COL_W-1:0];
      end
      CH_TAB: pc = {pc[COL_W:3], 3'b000} + (COL_W+1)'(TAB_STOP);
      CH_CR:  pc = '0;
      CH_LF: begin
        pr = pr + 1'b1;
        pc = '0;
      end
      default: begin
        put_we = 1'b1;
        pc     = pc + 1'b1;
      end
    endcase
    if (pc >= COLS_C) begin
      pc = pc - COLS_C;
      pr = pr + 1'b1;
    end
    scroll_need = (pr == ROWS_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.put) begin
      cur_col <= pc[COL_W-1:0];
      cur_row <= scroll_need ? ROW_W'(ROWS - 1) : pr[ROW_W-1:0];
    end else if (cmd.set_cur) begin
      cur_col <= ({1'b0, cmd_col} < COLS_C) ? cmd_col : COL_W'(COLS - 1);
      cur_row <= ({1'b0, cmd_row} < ROWS_C) ? cmd_row : ROW_W'(ROWS - 1);
    end else if (cmd.home) begin
      cur_col <= '0;
      cur_row <= '0;
    end
  end

  // sweep index shared by the reset fill, clear and scroll
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.put || cmd.home) begin
      idx <= '0;
    end else if (cmd.fill_init || cmd.fill_blank || cmd.copy_wr) begin
      idx <= idx + 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = blank;
    if (cmd.put) begin
      ram_we    = put_we;
      ram_waddr = cell_addr(put_wr, put_wc);
      ram_wdata = put_wdata;
    end else if (cmd.fill_init) begin
      ram_we    = 1'b1;
      ram_wdata = {RESET_ATTR, CH_SPACE};
    end else if (cmd.fill_blank) begin
      ram_we    = 1'b1;
    end else if (cmd.copy_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end
  end

  assign ram_re    = cmd.copy_rd || (cmd.cell_rd && in_range);
  assign ram_raddr = cmd.cell_rd ? cell_addr(cmd_row, cmd_col) : idx + ADDR_W'(COLS);

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_out) begin
      cursor_x      <= cur_col;
      cursor_y      <= cur_row;
      cursor_offset <= OFS_W'(cur_row) * OFS_W'(COLS) + OFS_W'(cur_col);
      cell_data     <= (cmd_kind == KIND_READ && in_range) ? ram_rdata : '0;
    end
  end

  assign status.kind        = cmd_kind;
  assign status.scroll_need = scroll_need;
  assign status.last_cell   = (idx == ADDR_W'(NCELLS - 1));
  assign status.last_copy   = (idx == ADDR_W'((ROWS - 1) * COLS - 1));
  assign status.out_free    = !out_valid || out_ready;

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < COLS_C) && ({1'b0, cur_row} < ROWS_C))
    else $error("cursor left the screen");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.put_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ----- verif/console_mirror_check.sv -----
// Checker for the text console writer: keeps a mirror of the screen, cursor and colours,
// predicts the report for every accepted command and compares the reports that come out.
// Depends on tccw_pkg; instantiated beside the DUT by text_console_char_writer_tb.
module console_mirror_check #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tccw_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [tccw_pkg::KIND_W-1:0]    kind,
  input  logic [tccw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tccw_pkg::COL_W-1:0]     col,
  input  logic [tccw_pkg::ROW_W-1:0]     row,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tccw_pkg::COL_W-1:0]     cursor_x,
  input  logic [tccw_pkg::ROW_W-1:0]     cursor_y,
  input  logic [tccw_pkg::OFS_W-1:0]     cursor_offset,
  input  logic [tccw_pkg::CELL_W-1:0]    cell_data,
  output int                             mismatches,
  output int                             awaiting
);

  import tccw_pkg::*;

  localparam int NCELLS = COLS * ROWS;

  typedef struct {
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [OFS_W-1:0]  ofs;
    logic [CELL_W-1:0] cdata;
  } cursor_report_t;

  logic [CELL_W-1:0] mirror_cells [NCELLS];
  int                cur_c;
  int                cur_r;
  logic [2:0]        fg_color;
  logic              fg_bright;
  logic [2:0]        bg_color;
  logic              bg_bright;
  cursor_report_t    reports_due [$];
  int                errs = 0;

  function automatic logic [ATTR_W-1:0] attr_byte();
    return {bg_bright, bg_color, fg_bright, fg_color};
  endfunction

  function automatic logic [CELL_W-1:0] blank_word();
    return {attr_byte(), CH_SPACE};
  endfunction

  task automatic fill_screen(input logic [CELL_W-1:0] w);
    for (int i = 0; i < NCELLS; i++) mirror_cells[i] = w;
  endtask

  task automatic scroll_up();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) mirror_cells[i] = mirror_cells[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < NCELLS; i++) mirror_cells[i] = blank_word();
    cur_r = ROWS - 1;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    if (ch == CH_BS) begin
      // backspace never wraps forward or scrolls; at the origin it is a no-op
      if (cur_c != 0 || cur_r != 0) begin
        if (cur_c == 0) begin
          cur_r--;
          cur_c = COLS - 1;
        end else begin
          cur_c--;
        end
        mirror_cells[cur_r * COLS + cur_c] = blank_word();
      end
    end else begin
      case (ch)
        CH_TAB: cur_c = (cur_c / TAB_STOP) * TAB_STOP + TAB_STOP;
        CH_CR:  cur_c = 0;
        CH_LF: begin
          cur_r++;
          cur_c = 0;
        end
        default: begin
          mirror_cells[cur_r * COLS + cur_c] = {attr_byte(), ch};
          cur_c++;
        end
      endcase
      if (cur_c >= COLS) begin
        cur_c -= COLS;
        cur_r++;
      end
      if (cur_r >= ROWS) scroll_up();
    end
  endtask

  task automatic mirror_command(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                                output cursor_report_t rep);
    logic [CELL_W-1:0] word;
    word = '0;
    case (kind_t'(k))
      KIND_PUT: put_char(ch);
      KIND_SET: begin
        cur_c = (int'(c) < COLS) ? int'(c) : COLS - 1;
        cur_r = (int'(r) < ROWS) ? int'(r) : ROWS - 1;
      end
      KIND_CLEAR: begin
        fill_screen(blank_word());
        cur_c = 0;
        cur_r = 0;
      end
      default: begin
        if (int'(r) < ROWS && int'(c) < COLS) word = mirror_cells[int'(r) * COLS + int'(c)];
      end
    endcase
    rep.x     = COL_W'(cur_c);
    rep.y     = ROW_W'(cur_r);
    rep.ofs   = OFS_W'(cur_r * COLS + cur_c);
    rep.cdata = word;
  endtask

  task automatic check_field(input string what, input int want, input int seen);
    if (want != seen) begin
      errs++;
      $display("%0t  %s mismatch: expected %0d, actual %0d", $time, what, want, seen);
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t rep;
    cursor_report_t got;
    if (rst) begin
      fill_screen({RESET_ATTR, CH_SPACE});
      cur_c     = 0;
      cur_r     = 0;
      fg_color  = RESET_ATTR[2:0];
      fg_bright = RESET_ATTR[3];
      bg_color  = RESET_ATTR[6:4];
      bg_bright = RESET_ATTR[7];
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          CFG_FG_COLOR:  fg_color  = cfg_wdata[2:0];
          CFG_FG_BRIGHT: fg_bright = cfg_wdata[0];
          CFG_BG_COLOR:  bg_color  = cfg_wdata[2:0];
          CFG_BG_BRIGHT: bg_bright = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        mirror_command(kind, char_code, col, row, rep);
        reports_due.push_back(rep);
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          errs++;
          $display("%0t  unexpected report: expected none, actual x=%0d y=%0d ofs=%0d cell=%h",
                   $time, cursor_x, cursor_y, cursor_offset, cell_data);
        end else begin
          got = reports_due.pop_front();
          check_field("cursor_x", got.x, cursor_x);
          check_field("cursor_y", got.y, cursor_y);
          check_field("cursor_offset", got.ofs, cursor_offset);
          check_field("cell_data", got.cdata, cell_data);
        end
      end
    end
    mismatches <= errs;
    awaiting   <= reports_due.size();
  end

endmodule

// ----- verif/text_console_char_writer_tb.sv -----
// Top of the text console writer testbench: clock, reset, colour writes and command stimulus.
// Depends on tccw_pkg, text_console_char_writer and console_mirror_check, which does the checking.
module text_console_char_writer_tb;
  import tccw_pkg::*;

  localparam int COLS          = 80;
  localparam int ROWS          = 25;
  localparam int PHASES        = 6;
  localparam int PER_PHASE     = 300;
  localparam int CALM_ITEMS    = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 30_000_000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind      = '0;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [COL_W-1:0]     col       = '0;
  logic [ROW_W-1:0]     row       = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COL_W-1:0]     cursor_x;
  logic [ROW_W-1:0]     cursor_y;
  logic [OFS_W-1:0]     cursor_offset;
  logic [CELL_W-1:0]    cell_data;
  int                   mismatches;
  int                   awaiting;

  int issued      = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  text_console_char_writer #(.COLS(COLS), .ROWS(ROWS)) DUT (.*);

  console_mirror_check #(.COLS(COLS), .ROWS(ROWS)) u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Valid is only lowered when a gap is taken, so back-to-back items keep it high
  task automatic send_cmd(input kind_t k, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    col       <= x;
    row       <= y;
    do @(posedge clk); while (!in_ready);
    issued++;
  endtask

  task automatic put_ch(input logic [CHAR_W-1:0] ch);
    send_cmd(KIND_PUT, ch, COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic at_cell(input kind_t k, input int x, input int y);
    send_cmd(k, CHAR_W'($urandom), COL_W'(x), ROW_W'(y));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_colours(input logic [2:0] fgc, input logic fgb,
                              input logic [2:0] bgc, input logic bgb);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FG_COLOR;
    cfg_wdata <= fgc;
    @(posedge clk);
    cfg_idx   <= CFG_FG_BRIGHT;
    cfg_wdata <= {(CFG_W-1)'($urandom), fgb};
    @(posedge clk);
    cfg_idx   <= CFG_BG_COLOR;
    cfg_wdata <= bgc;
    @(posedge clk);
    cfg_idx   <= CFG_BG_BRIGHT;
    cfg_wdata <= {(CFG_W-1)'($urandom), bgb};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom); while (b == CH_BS || b == CH_TAB || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] edit_byte();
    case ($urandom_range(0, 7))
      0:       return CH_BS;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_LF;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  // mostly on screen, now and then anywhere the field allows
  function automatic int pick_col();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(0, COLS - 1);
  endfunction

  function automatic int pick_row();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, ROWS - 1);
  endfunction

  task automatic random_segment();
    int sel;
    int n;
    int x;
    int y;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      // a line of text, sometimes ended by CR LF
      n = $urandom_range(1, 30);
      repeat (n) put_ch(text_byte());
      if ($urandom_range(0, 2) == 0) begin
        put_ch(CH_CR);
        put_ch(CH_LF);
      end
    end else if (sel < 65) begin
      // place, write, read back along the same row
      x = $urandom_range(0, COLS - 1);
      y = $urandom_range(0, ROWS - 1);
      at_cell(KIND_SET, x, y);
      n = $urandom_range(1, 6);
      repeat (n) put_ch(text_byte());
      for (int j = 0; j < n; j++) at_cell(KIND_READ, x + j, y);
    end else if (sel < 80) begin
      n = $urandom_range(1, 8);
      repeat (n) put_ch(edit_byte());
    end else if (sel < 90) begin
      at_cell(KIND_SET, pick_col(), pick_row());
      n = $urandom_range(1, 4);
      repeat (n) at_cell(KIND_READ, pick_col(), pick_row());
    end else if (sel < 98) begin
      n = $urandom_range(1, 3);
      repeat (n) send_cmd(kind_t'($urandom_range(0, 3)), CHAR_W'($urandom),
                          COL_W'($urandom), ROW_W'($urandom));
    end else begin
      at_cell(KIND_CLEAR, pick_col(), pick_row());
    end
  endtask

  // receiver: random short stalls, or one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase_end;
    int last_item;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset colours, field extremes, every command, wrap and scroll cases
    at_cell(KIND_READ, 0, 0);
    at_cell(KIND_READ, COLS - 1, ROWS - 1);
    at_cell(KIND_READ, 127, 63);
    at_cell(KIND_READ, 0, ROWS);
    put_ch(CH_BS);                      // backspace at origin
    put_ch(8'h41);
    put_ch(8'hFF);
    put_ch(8'h00);
    put_ch(CH_TAB);
    put_ch(CH_TAB);
    at_cell(KIND_READ, 0, 0);
    at_cell(KIND_SET, COLS - 3, 0);
    put_ch(CH_TAB);                     // tab past the line end wraps
    put_ch(CH_BS);                      // back over the line start
    put_ch(CH_CR);
    put_ch(CH_LF);
    at_cell(KIND_SET, 127, 63);         // saturates to the last cell
    put_ch(8'h5A);                      // wrap off the last row scrolls
    at_cell(KIND_READ, COLS - 1, ROWS - 2);
    at_cell(KIND_SET, 5, ROWS - 1);
    put_ch(CH_LF);
    at_cell(KIND_SET, COLS - 1, ROWS - 1);
    put_ch(CH_TAB);
    at_cell(KIND_CLEAR, 0, 0);
    at_cell(KIND_READ, 0, 0);
    at_cell(KIND_SET, 0, 10);
    put_ch(CH_BS);

    last_item = issued + PHASES * PER_PHASE;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       load_colours(3'd0, 1'b0, 3'd0, 1'b0);
        1:       load_colours(3'd7, 1'b1, 3'd7, 1'b1);
        default: load_colours(3'($urandom), 1'($urandom), 3'($urandom), 1'($urandom));
      endcase
      if (p == 2) hold_req = 1'b1;     // sender keeps offering while the output is held
      phase_end = issued + PER_PHASE;
      while (issued < phase_end) begin
        if (issued >= last_item - CALM_ITEMS) calm = 1'b1;
        random_segment();
      end
    end

    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
